/* hw/rtl/mbsc_pkg.sv */
// ----------------------------------------------------------------------------
// mbsc_pkg
// shared types and constants of the mailbox sequence checker
// ----------------------------------------------------------------------------
package mbsc_pkg;

  localparam int unsigned WINDOW_W    = 31;
  localparam int unsigned THRESH_W    = 8;
  localparam int unsigned RUN_W       = 8;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned RX_W        = 32;
  localparam int unsigned CFG_ADDR_W  = 1;
  localparam int unsigned CFG_DATA_W  = 31;
  localparam int unsigned IN_DATA_W   = 40;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(1024);
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(8);

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESH = 1'b1;

  // operation codes, the high bit alone selects arm
  localparam logic [FUNC_W-1:0] FUNC_VALIDATE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COMMIT   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ARM      = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SPARE    = 2'd3;

  typedef enum logic [2:0] {
    OC_IN_ORDER = 3'd0,
    OC_PENDING  = 3'd1,
    OC_GAP      = 3'd2,
    OC_FORCED   = 3'd3,
    OC_RANGE    = 3'd4,
    OC_REJECTED = 3'd5,
    OC_COMMIT   = 3'd6,
    OC_ARMED    = 3'd7
  } outcome_t;

  typedef struct packed {
    logic [WINDOW_W-1:0] window;
    logic [THRESH_W-1:0] threshold;
  } cfg_t;

endpackage

/* hw/rtl/mbsc_core.sv */
// ----------------------------------------------------------------------------
// mbsc_core
// sequence state registers and the per-item decision logic
// ----------------------------------------------------------------------------
module mbsc_core #(
  parameter int unsigned SEQ_BITS = 31
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fire,
  input  logic [mbsc_pkg::FUNC_W-1:0]       func,
  input  logic [mbsc_pkg::RX_W-1:0]         rx,
  input  mbsc_pkg::cfg_t                    cfg,
  output logic                              accepted,
  output mbsc_pkg::outcome_t                outcome,
  output logic [SEQ_BITS-1:0]               exp_before,
  output logic [SEQ_BITS-1:0]               exp_after,
  output logic [SEQ_BITS-1:0]               outb_now,
  output logic [mbsc_pkg::RUN_W-1:0]        run_now
);
  import mbsc_pkg::*;

  logic [SEQ_BITS-1:0] exp_r, exp_nxt;
  logic [SEQ_BITS-1:0] outb_r, outb_nxt;
  logic                armed_r, armed_nxt;
  logic [RUN_W-1:0]    run_r, run_nxt;

  logic [SEQ_BITS-1:0] rx_s;
  logic [SEQ_BITS-1:0] gap;
  logic                out_of_range;
  logic                in_window;
  logic [RUN_W-1:0]    run_inc;

  assign rx_s         = rx[SEQ_BITS-1:0];
  assign out_of_range = |(rx >> SEQ_BITS);
  assign gap          = rx_s - exp_r;
  assign in_window    = (33'(gap) <= 33'(cfg.window));
  assign run_inc      = run_r + RUN_W'(1);

  always_comb begin
    exp_nxt   = exp_r;
    outb_nxt  = outb_r;
    armed_nxt = armed_r;
    run_nxt   = run_r;
    accepted  = 1'b1;
    outcome   = OC_ARMED;
    if (func[1]) begin
      armed_nxt = 1'b1;
      outcome   = OC_ARMED;
    end else if (func == FUNC_COMMIT) begin
      outb_nxt = outb_r + SEQ_BITS'(1);
      outcome  = OC_COMMIT;
    end else if (out_of_range) begin
      accepted = 1'b0;
      outcome  = OC_RANGE;
    end else if (armed_r) begin
      armed_nxt = 1'b0;
      run_nxt   = '0;
      exp_nxt   = rx_s + SEQ_BITS'(1);
      outcome   = OC_PENDING;
    end else if (rx_s == exp_r) begin
      run_nxt = '0;
      exp_nxt = rx_s + SEQ_BITS'(1);
      outcome = OC_IN_ORDER;
    end else if (in_window) begin
      run_nxt = '0;
      exp_nxt = rx_s + SEQ_BITS'(1);
      outcome = OC_GAP;
    end else if (run_inc >= cfg.threshold) begin
      run_nxt = '0;
      exp_nxt = rx_s + SEQ_BITS'(1);
      outcome = OC_FORCED;
    end else begin
      run_nxt  = run_inc;
      accepted = 1'b0;
      outcome  = OC_REJECTED;
    end
  end

  assign exp_before = exp_r;
  assign exp_after  = exp_nxt;
  assign outb_now   = outb_nxt;
  assign run_now    = run_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r   <= '0;
      outb_r  <= '0;
      armed_r <= 1'b0;
      run_r   <= '0;
    end else if (fire) begin
      exp_r   <= exp_nxt;
      outb_r  <= outb_nxt;
      armed_r <= armed_nxt;
      run_r   <= run_nxt;
    end
  end

endmodule

/* hw/rtl/mailbox_sequence_checker.sv */
// an accepted item passes the input register and then the result register before its result is valid
// throughput: one item per cycle while out_tready stays high, set by the state update in mbsc_core
// a result held by out_tready low stalls the input once the input stage holds an item
// reset (rst_n low, synchronous) clears both stages, all sequence state and the resync flag
// and reloads the window and threshold registers with their defaults
// ----------------------------------------------------------------------------
// mailbox_sequence_checker
// mailbox sequence tracker with gap window, escalation and armed resync
// ----------------------------------------------------------------------------
module mailbox_sequence_checker #(
  parameter int unsigned SEQ_BITS = 31
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // func[1:0], rx_seq[33:2]
  input  logic [mbsc_pkg::IN_DATA_W-1:0]         in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // accepted, outcome, expected_before, expected_after, outbound_now, mismatch_run
  output logic [((12+3*SEQ_BITS+7)/8)*8-1:0]     out_tdata,
  input  logic                                   cfg_we,
  input  logic [mbsc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [mbsc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import mbsc_pkg::*;

  localparam int unsigned OUT_W = ((12+3*SEQ_BITS+7)/8)*8;

  cfg_t cfg_r;

  logic              s1_valid_r;
  logic [FUNC_W-1:0] s1_func_r;
  logic [RX_W-1:0]   s1_rx_r;
  logic              adv;

  logic                accepted;
  outcome_t            outcome;
  logic [SEQ_BITS-1:0] exp_before;
  logic [SEQ_BITS-1:0] exp_after;
  logic [SEQ_BITS-1:0] outb_now;
  logic [RUN_W-1:0]    run_now;

  logic                out_valid_r;
  logic                acc_r;
  outcome_t            oc_r;
  logic [SEQ_BITS-1:0] before_r;
  logic [SEQ_BITS-1:0] after_r;
  logic [SEQ_BITS-1:0] outb_r;
  logic [RUN_W-1:0]    run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window    <= WINDOW_RESET;
      cfg_r.threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_WINDOW: cfg_r.window    <= cfg_wdata[WINDOW_W-1:0];
        CFG_THRESH: cfg_r.threshold <= cfg_wdata[THRESH_W-1:0];
        default:    cfg_r           <= cfg_r;
      endcase
    end
  end

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_func_r <= in_tdata[FUNC_W-1:0];
      s1_rx_r   <= in_tdata[FUNC_W+RX_W-1:FUNC_W];
    end
  end

  mbsc_core #(
    .SEQ_BITS (SEQ_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (adv),
    .func       (s1_func_r),
    .rx         (s1_rx_r),
    .cfg        (cfg_r),
    .accepted   (accepted),
    .outcome    (outcome),
    .exp_before (exp_before),
    .exp_after  (exp_after),
    .outb_now   (outb_now),
    .run_now    (run_now)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r    <= accepted;
      oc_r     <= outcome;
      before_r <= exp_before;
      after_r  <= exp_after;
      outb_r   <= outb_now;
      run_r    <= run_now;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({run_r, outb_r, after_r, before_r, oc_r, acc_r});

`ifndef ASSERT_OFF
  a_reject_codes : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !acc_r) |-> (oc_r == OC_RANGE || oc_r == OC_REJECTED))
    else $error("rejected item carries an accepting outcome");

  a_resync_clears_run : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (oc_r == OC_IN_ORDER || oc_r == OC_PENDING ||
                     oc_r == OC_GAP || oc_r == OC_FORCED)) |-> (run_r == '0))
    else $error("mismatch run not cleared on resync");

  a_range_keeps_expected : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && oc_r == OC_RANGE) |-> (after_r == before_r))
    else $error("out of range item moved the expected number");

  a_resync_sets_expected : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !s1_func_r[1] && s1_func_r != FUNC_COMMIT && s1_rx_r[SEQ_BITS-1:0] == exp_before
     && !(|(s1_rx_r >> SEQ_BITS))) |=> (after_r == before_r + SEQ_BITS'(1)))
    else $error("in-order item did not advance the expected number");
`endif

endmodule

/* test/mailbox_sequence_checker_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mailbox_sequence_checker_test
// self-checking bench for the mailbox sequence tracker: a short table of
// directed items at the reset settings, then weighted random traffic over
// several window and threshold settings, every result compared field by
// field against the row's own want values or a behavioral tracker kept in the bench
// ----------------------------------------------------------------------------
module mailbox_sequence_checker_test;
  import mbsc_pkg::*;

  localparam int unsigned SEQ_W       = 31;
  localparam int unsigned RES_W       = 12 + 3 * SEQ_W;
  localparam int unsigned OUT_W       = ((RES_W + 7) / 8) * 8;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_ITEMS = 95;
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [RUN_W-1:0] run;
    logic [SEQ_W-1:0] outbound;
    logic [SEQ_W-1:0] after;
    logic [SEQ_W-1:0] prev;
    outcome_t         outcome;
    logic             ok;
  } result_t;

  typedef struct {
    logic [FUNC_W-1:0] f;
    logic [RX_W-1:0]   rx;
    bit                typed;
    result_t           want;
  } row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // tracker state and register copies
  logic [SEQ_W-1:0]    trk_expected = '0;
  logic [SEQ_W-1:0]    trk_outbound = '0;
  logic                trk_armed    = 1'b0;
  logic [RUN_W-1:0]    trk_run      = '0;
  logic [WINDOW_W-1:0] reg_window   = WINDOW_RESET;
  logic [THRESH_W-1:0] reg_thresh   = THRESH_RESET;

  result_t     seq_results [$];
  row_t        rows [$];
  bit          gaps_on      = 1'b1;
  int unsigned errors       = 0;
  int unsigned n_items      = 0;
  int unsigned n_results    = 0;
  int unsigned n_settings   = 1;
  int unsigned seen [8]     = '{default: 0};
  int unsigned stall_left   = 0;
  int unsigned quiet        = 0;
  result_t     mon_got;
  result_t     mon_want;

  mailbox_sequence_checker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t track_item(input logic [FUNC_W-1:0] f,
                                         input logic [RX_W-1:0] rx);
    result_t r;
    logic [SEQ_W-1:0] gap;
    r.ok = 1'b1;
    r.prev = trk_expected;
    if (f[1]) begin
      trk_armed = 1'b1;
      r.outcome = OC_ARMED;
    end else if (f == FUNC_COMMIT) begin
      trk_outbound = trk_outbound + 31'd1;
      r.outcome = OC_COMMIT;
    end else if (rx[31]) begin
      r.ok = 1'b0;
      r.outcome = OC_RANGE;
    end else if (trk_armed) begin
      trk_armed = 1'b0;
      trk_run = '0;
      trk_expected = rx[SEQ_W-1:0] + 31'd1;
      r.outcome = OC_PENDING;
    end else if (rx[SEQ_W-1:0] == trk_expected) begin
      trk_run = '0;
      trk_expected = rx[SEQ_W-1:0] + 31'd1;
      r.outcome = OC_IN_ORDER;
    end else begin
      gap = rx[SEQ_W-1:0] - trk_expected;
      if (gap <= reg_window) begin
        trk_run = '0;
        trk_expected = rx[SEQ_W-1:0] + 31'd1;
        r.outcome = OC_GAP;
      end else begin
        trk_run = trk_run + 8'd1;
        if (trk_run >= reg_thresh) begin
          trk_run = '0;
          trk_expected = rx[SEQ_W-1:0] + 31'd1;
          r.outcome = OC_FORCED;
        end else begin
          r.ok = 1'b0;
          r.outcome = OC_REJECTED;
        end
      end
    end
    r.after = trk_expected;
    r.outbound = trk_outbound;
    r.run = trk_run;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (errors < 50)
      $display("mismatch in %s at result %0d: got %0h, want %0h", what, n_results, got, want);
    errors++;
  endtask

  task automatic add_row(input logic [FUNC_W-1:0] f, input logic [RX_W-1:0] rx,
                         input int unsigned typed = 0, input int unsigned ok = 0,
                         input outcome_t oc = OC_IN_ORDER, input int unsigned b = 0,
                         input int unsigned a = 0, input int unsigned o = 0,
                         input int unsigned run = 0);
    row_t row;
    row.f = f;
    row.rx = rx;
    row.typed = (typed != 0);
    row.want = '{run: RUN_W'(run), outbound: SEQ_W'(o), after: SEQ_W'(a),
                 prev: SEQ_W'(b), outcome: oc, ok: 1'(ok)};
    rows.push_back(row);
  endtask

  // called on a rising edge; returns on the edge that took the item, or after the random idle gap that may follow it
  task automatic put_item(input logic [FUNC_W-1:0] f, input logic [RX_W-1:0] rx,
                          input bit typed = 1'b0, input result_t fixed = '0);
    result_t r;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, rx, f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = track_item(f, rx);
    seq_results.push_back(typed ? fixed : r);
    n_items++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (seq_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] window, input logic [CFG_DATA_W-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_WINDOW;
    cfg_wdata <= window;
    @(posedge clk);
    reg_window = window;
    cfg_addr  <= CFG_THRESH;
    cfg_wdata <= thr;
    @(posedge clk);
    reg_thresh = thr[THRESH_W-1:0];
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // result side: checking, stalls and the progress watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        mon_got = result_t'(out_tdata[RES_W-1:0]);
        n_results++;
        if (seq_results.size() == 0) begin
          report("unexpected result", out_tdata[31:0], 32'h0);
        end else begin
          mon_want = seq_results.pop_front();
          seen[mon_want.outcome]++;
          if (mon_got.ok !== mon_want.ok)
            report("accepted", 32'(mon_got.ok), 32'(mon_want.ok));
          if (mon_got.outcome !== mon_want.outcome)
            report("outcome", 32'(mon_got.outcome), 32'(mon_want.outcome));
          if (mon_got.prev !== mon_want.prev)
            report("expected_before", 32'(mon_got.prev), 32'(mon_want.prev));
          if (mon_got.after !== mon_want.after)
            report("expected_after", 32'(mon_got.after), 32'(mon_want.after));
          if (mon_got.outbound !== mon_want.outbound)
            report("outbound_now", 32'(mon_got.outbound), 32'(mon_want.outbound));
          if (mon_got.run !== mon_want.run)
            report("mismatch_run", 32'(mon_got.run), 32'(mon_want.run));
        end
      end
      if (stall_left != 0)
        stall_left = stall_left - 1;
      else if (gaps_on && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 13);
      out_tready <= (stall_left == 0);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                 quiet, seq_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] win_set [PHASES];
    logic [CFG_DATA_W-1:0] thr_set [PHASES];
    logic [SEQ_W-1:0]      s31;
    logic [FUNC_W-1:0]     f;
    logic [RX_W-1:0]       rx;
    int unsigned           pick;
    int unsigned           burst;
    int unsigned           n_phase;

    // directed items at the reset settings (window 1024, threshold 8)
    add_row(FUNC_VALIDATE, 32'd0,          1, 1, OC_IN_ORDER, 0,    1,    0, 0);
    add_row(FUNC_COMMIT,   32'd0,          1, 1, OC_COMMIT,   1,    1,    1, 0);
    add_row(FUNC_VALIDATE, 32'h8000_0000,  1, 0, OC_RANGE,    1,    1,    1, 0);
    add_row(FUNC_VALIDATE, 32'hFFFF_FFFF,  1, 0, OC_RANGE,    1,    1,    1, 0);
    add_row(FUNC_VALIDATE, 32'h7FFF_FFFF,  1, 0, OC_REJECTED, 1,    1,    1, 1);
    // gap equal to the window, then one past it
    add_row(FUNC_VALIDATE, 32'd1025,       1, 1, OC_GAP,      1,    1026, 1, 0);
    add_row(FUNC_VALIDATE, 32'd2051,       1, 0, OC_REJECTED, 1026, 1026, 1, 1);
    add_row(FUNC_ARM,      32'hFFFF_FFFF,  1, 1, OC_ARMED,    1026, 1026, 1, 1);
    // out of range leaves the resync armed
    add_row(FUNC_VALIDATE, 32'hFFFF_FFFF,  1, 0, OC_RANGE,    1026, 1026, 1, 1);
    add_row(FUNC_VALIDATE, 32'h7FFF_FFFF,  1, 1, OC_PENDING,  1026, 0,    1, 0);
    add_row(FUNC_SPARE,    32'h0000_0000,  1, 1, OC_ARMED,    0,    0,    1, 0);
    add_row(FUNC_VALIDATE, 32'd5,          1, 1, OC_PENDING,  0,    6,    1, 0);
    add_row(FUNC_VALIDATE, 32'd6,          1, 1, OC_IN_ORDER, 6,    7,    1, 0);
    add_row(FUNC_COMMIT,   32'h5555_AAAA,  1, 1, OC_COMMIT,   7,    7,    2, 0);
    repeat (7) add_row(FUNC_VALIDATE, 32'd3);
    add_row(FUNC_VALIDATE, 32'd3,          1, 1, OC_FORCED,   7,    4,    2, 0);
    add_row(FUNC_VALIDATE, 32'd4);
    add_row(FUNC_VALIDATE, 32'h0000_0100);

    win_set = '{31'd0, 31'h7FFF_FFFF, 31'd16, CFG_DATA_W'($urandom), 31'd1024,
                CFG_DATA_W'($urandom_range(0, 4096)), 31'd100};
    thr_set = '{31'd1, 31'd255, 31'd3, CFG_DATA_W'($urandom_range(1, 255)), 31'h7FFF_FF05,
                CFG_DATA_W'($urandom_range(2, 20)), 31'd8};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) put_item(rows[i].f, rows[i].rx, rows[i].typed, rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p == PHASES - 1) gaps_on = 1'b0;
      set_regs(win_set[p], thr_set[p]);
      n_phase = 0;
      while (n_phase < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        f = FUNC_VALIDATE;
        if (pick < 35) begin
          rx = {1'b0, trk_expected};
        end else if (pick < 50) begin
          s31 = trk_expected + ((reg_window == 0) ? 31'd1 :
                SEQ_W'($urandom_range(1, (reg_window > 2000) ? 2000 : reg_window)));
          rx = {1'b0, s31};
        end else if (pick < 55) begin
          s31 = trk_expected + reg_window + SEQ_W'($urandom_range(0, 1));
          rx = {1'b0, s31};
        end else if (pick < 65) begin
          rx = $urandom;
        end else if (pick < 72) begin
          rx = {1'b1, 31'($urandom)};
        end else if (pick < 82) begin
          f = FUNC_COMMIT;
          rx = $urandom;
        end else if (pick < 89) begin
          f = ($urandom_range(0, 1) == 0) ? FUNC_ARM : FUNC_SPARE;
          rx = $urandom;
        end else begin
          // run of stale numbers to reach the escalation threshold
          burst = $urandom_range(1, reg_thresh + 1);
          repeat (burst - 1) begin
            s31 = trk_expected - SEQ_W'($urandom_range(1, 1000));
            put_item(FUNC_VALIDATE, {1'b0, s31});
            n_phase++;
          end
          s31 = trk_expected - SEQ_W'($urandom_range(1, 1000));
          rx = {1'b0, s31};
        end
        put_item(f, rx);
        n_phase++;
        if (p == 2 && n_phase == PHASE_ITEMS / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("ran %0d items over %0d register settings, %0d results checked",
             n_items, n_settings, n_results);
    $write("outcomes in-order %0d pending %0d gap %0d forced %0d",
           seen[0], seen[1], seen[2], seen[3]);
    $display(" range %0d rejected %0d commit %0d armed %0d",
             seen[4], seen[5], seen[6], seen[7]);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/mbsc_pkg.sv
hw/rtl/mbsc_core.sv
hw/rtl/mailbox_sequence_checker.sv
test/mailbox_sequence_checker_test.sv
